[rtl/core/boxavg_pkg.sv]
// ----------------------------------------------------------------------------
// boxavg_pkg
// Shared widths, register indexes and lane control types of the box average
// downsampler.
// ----------------------------------------------------------------------------
package boxavg_pkg;

    localparam int CHANNELS   = 3;
    localparam int FACTOR_W   = 5;
    localparam int SWIDTH_W   = 11;
    localparam int SHEIGHT_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_W      = 12;
    localparam int AREA_W     = 2 * FACTOR_W;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR        = 2'd2;

    typedef struct packed {
        logic rd_en;      // fetch the column sum
        logic upd_en;     // write back the updated column sum
        logic fresh;      // first row of a block row: sum restarts
        logic div_start;  // block complete: start the average
    } t_lane_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_lane_sts;

endpackage

[rtl/core/box_average_downsampler.sv]
// ----------------------------------------------------------------------------
// box_average_downsampler
// Integer box-filter downscaler for a raster RGB stream: sums each channel
// over factor-by-factor blocks in per-column memories and emits the
// truncated block average with its output row and column.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    red, green, blue, frame_start
//  out       output     o_out_valid / i_out_stall  avg rgb, row, col, frame_last
//  cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
//  a pixel that closes no block is accepted, then its column sum is updated
//  a block-closing pixel, after the update, runs the one-bit-per-cycle divider
//  that each channel lane runs for the average, then waits for a free output register
//  a finished word waits in the output register while the next pixels enter
//  synchronous reset; sum memories are not cleared, a block row rewrites them
// ----------------------------------------------------------------------------
module box_average_downsampler import boxavg_pkg::*; #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_FACTOR   = 16,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [CHANNEL_BITS-1:0] i_red_in,
    input  logic [CHANNEL_BITS-1:0] i_green_in,
    input  logic [CHANNEL_BITS-1:0] i_blue_in,
    input  logic                    i_frame_start,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [CHANNEL_BITS-1:0] o_avg_red,
    output logic [CHANNEL_BITS-1:0] o_avg_green,
    output logic [CHANNEL_BITS-1:0] o_avg_blue,
    output logic [ROW_W-1:0]        o_out_row,
    output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] o_out_col,
    output logic                    o_frame_last
);

    localparam int EFF_MAX_F = (MAX_FACTOR < 31) ? MAX_FACTOR : 31;
    localparam int SUM_W     = CHANNEL_BITS + 2 * $clog2(EFF_MAX_F);
    localparam int ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCNT_W    = $clog2(MAX_WIDTH + 1);
    localparam int CPROD_W   = WCNT_W + 1 + FACTOR_W;
    localparam int RPROD_W   = ROW_W + 1 + FACTOR_W;
    localparam int OUT_KEEP  = (CHANNEL_BITS < 8) ? CHANNEL_BITS : 8;
    localparam logic [CHANNEL_BITS-1:0] AVG_MASK =
        CHANNEL_BITS'((33'(1) << OUT_KEEP) - 33'(1));

    typedef enum logic [1:0] {S_IDLE, S_UPD, S_DIV, S_OUT} t_state;

    // configuration
    logic [SWIDTH_W-1:0]  r_source_width;
    logic [SHEIGHT_W-1:0] r_source_height;
    logic [FACTOR_W-1:0]  r_factor;

    // raster position
    logic [WCNT_W-1:0]   r_src_col;
    logic [ROW_W-1:0]    r_src_row;
    logic [FACTOR_W-1:0] r_wbc;
    logic [FACTOR_W-1:0] r_wbr;
    logic [WCNT_W-1:0]   r_bci;
    logic [ROW_W-1:0]    r_bri;

    // word being processed
    logic [CHANNEL_BITS-1:0] r_px [CHANNELS];
    logic [ADDR_W-1:0]       r_idx;
    logic [ROW_W-1:0]        r_row;
    logic                    r_fresh;
    logic                    r_in_range;
    logic                    r_complete;
    logic                    r_last;

    // fsm and output register
    t_state                  r_state;
    logic                    r_out_valid;
    logic [CHANNEL_BITS-1:0] r_avg [CHANNELS];
    logic [ROW_W-1:0]        r_out_row;
    logic [ADDR_W-1:0]       r_out_col;
    logic                    r_frame_last;

    logic [WCNT_W-1:0]    w_w;
    logic [SHEIGHT_W-1:0] w_h;
    logic [FACTOR_W-1:0]  w_f;
    logic [AREA_W-1:0]    w_area;

    logic                w_in_acc;
    logic [WCNT_W-1:0]   c_src_col;
    logic [ROW_W-1:0]    c_src_row;
    logic [FACTOR_W-1:0] c_wbc;
    logic [FACTOR_W-1:0] c_wbr;
    logic [WCNT_W-1:0]   c_bci;
    logic [ROW_W-1:0]    c_bri;

    logic [CPROD_W-1:0] w_col_end;
    logic [CPROD_W-1:0] w_col_next;
    logic [RPROD_W-1:0] w_row_end;
    logic [RPROD_W-1:0] w_row_next;
    logic               w_col_ok;
    logic               w_row_ok;
    logic               w_complete;
    logic               w_last;

    logic [WCNT_W-1:0]   n_src_col;
    logic [ROW_W-1:0]    n_src_row;
    logic [FACTOR_W-1:0] n_wbc;
    logic [FACTOR_W-1:0] n_wbr;
    logic [WCNT_W-1:0]   n_bci;
    logic [ROW_W-1:0]    n_bri;

    t_lane_ctl         w_ctl;
    t_lane_sts         w_sts [CHANNELS];
    logic [SUM_W-1:0]  w_quo [CHANNELS];
    logic [ADDR_W-1:0] w_addr;
    logic              w_out_free;
    logic              w_out_load;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width  <= SWIDTH_W'(1);
            r_source_height <= SHEIGHT_W'(1);
            r_factor        <= FACTOR_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SOURCE_WIDTH:  r_source_width  <= i_cfg_data[SWIDTH_W-1:0];
                CFG_SOURCE_HEIGHT: r_source_height <= i_cfg_data[SHEIGHT_W-1:0];
                CFG_FACTOR:        r_factor        <= i_cfg_data[FACTOR_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, oversize acts as the maximum
    always_comb begin
        if (r_source_width == '0) begin
            w_w = WCNT_W'(1);
        end else if (32'(r_source_width) > 32'(MAX_WIDTH)) begin
            w_w = WCNT_W'(MAX_WIDTH);
        end else begin
            w_w = WCNT_W'(r_source_width);
        end
        if (r_source_height == '0) begin
            w_h = SHEIGHT_W'(1);
        end else if (32'(r_source_height) > 32'(MAX_HEIGHT)) begin
            w_h = SHEIGHT_W'(MAX_HEIGHT);
        end else begin
            w_h = r_source_height;
        end
        if (r_factor == '0) begin
            w_f = FACTOR_W'(1);
        end else if (32'(r_factor) > 32'(MAX_FACTOR)) begin
            w_f = FACTOR_W'(MAX_FACTOR);
        end else begin
            w_f = r_factor;
        end
        w_area = AREA_W'(w_f) * AREA_W'(w_f);
    end

    // ------------------------------------------------------------------
    // raster position and block tests
    // ------------------------------------------------------------------
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_comb begin
        c_src_col = i_frame_start ? '0 : r_src_col;
        c_src_row = i_frame_start ? '0 : r_src_row;
        c_wbc     = i_frame_start ? '0 : r_wbc;
        c_wbr     = i_frame_start ? '0 : r_wbr;
        c_bci     = i_frame_start ? '0 : r_bci;
        c_bri     = i_frame_start ? '0 : r_bri;

        // block k lies inside the frame when (k+1)*f <= size
        w_col_end  = (CPROD_W'(c_bci) + CPROD_W'(1)) * CPROD_W'(w_f);
        w_col_next = (CPROD_W'(c_bci) + CPROD_W'(2)) * CPROD_W'(w_f);
        w_row_end  = (RPROD_W'(c_bri) + RPROD_W'(1)) * RPROD_W'(w_f);
        w_row_next = (RPROD_W'(c_bri) + RPROD_W'(2)) * RPROD_W'(w_f);
        w_col_ok   = (w_col_end <= CPROD_W'(w_w));
        w_row_ok   = (w_row_end <= RPROD_W'(w_h));
        w_last     = (w_col_next > CPROD_W'(w_w)) && (w_row_next > RPROD_W'(w_h));
        w_complete = (c_wbc >= w_f - FACTOR_W'(1)) && (c_wbr >= w_f - FACTOR_W'(1));

        n_src_col = c_src_col;
        n_src_row = c_src_row;
        n_wbc     = c_wbc;
        n_wbr     = c_wbr;
        n_bci     = c_bci;
        n_bri     = c_bri;
        if ((WCNT_W + 1)'(c_src_col) + (WCNT_W + 1)'(1) >= (WCNT_W + 1)'(w_w)) begin
            n_src_col = '0;
            n_wbc     = '0;
            n_bci     = '0;
            if (SHEIGHT_W'(c_src_row) + SHEIGHT_W'(1) >= w_h) begin
                n_src_row = '0;
                n_wbr     = '0;
                n_bri     = '0;
            end else begin
                n_src_row = c_src_row + ROW_W'(1);
                if ((FACTOR_W + 1)'(c_wbr) + (FACTOR_W + 1)'(1) >= (FACTOR_W + 1)'(w_f)) begin
                    n_wbr = '0;
                    n_bri = c_bri + ROW_W'(1);
                end else begin
                    n_wbr = c_wbr + FACTOR_W'(1);
                end
            end
        end else begin
            n_src_col = c_src_col + WCNT_W'(1);
            if ((FACTOR_W + 1)'(c_wbc) + (FACTOR_W + 1)'(1) >= (FACTOR_W + 1)'(w_f)) begin
                n_wbc = '0;
                n_bci = c_bci + WCNT_W'(1);
            end else begin
                n_wbc = c_wbc + FACTOR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col <= '0;
            r_src_row <= '0;
            r_wbc     <= '0;
            r_wbr     <= '0;
            r_bci     <= '0;
            r_bri     <= '0;
        end else if (w_in_acc) begin
            r_src_col <= n_src_col;
            r_src_row <= n_src_row;
            r_wbc     <= n_wbc;
            r_wbr     <= n_wbr;
            r_bci     <= n_bci;
            r_bri     <= n_bri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_px[0]    <= i_red_in;
            r_px[1]    <= i_green_in;
            r_px[2]    <= i_blue_in;
            r_idx      <= c_bci[ADDR_W-1:0];
            r_row      <= c_bri;
            r_fresh    <= (c_wbr == '0);
            r_in_range <= w_col_ok && w_row_ok;
            r_complete <= w_complete;
            r_last     <= w_last;
        end
    end

    // ------------------------------------------------------------------
    // channel lanes
    // ------------------------------------------------------------------
    always_comb begin
        w_ctl.rd_en     = w_in_acc;
        w_ctl.upd_en    = (r_state == S_UPD) && r_in_range;
        w_ctl.fresh     = r_fresh;
        w_ctl.div_start = (r_state == S_UPD) && r_in_range && r_complete;
    end

    assign w_addr = (r_state == S_IDLE) ? c_bci[ADDR_W-1:0] : r_idx;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        boxavg_lane #(
            .CHANNEL_BITS (CHANNEL_BITS),
            .SUM_W        (SUM_W),
            .DEPTH        (MAX_WIDTH),
            .ADDR_W       (ADDR_W)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_addr  (w_addr),
            .i_px    (r_px[g]),
            .i_area  (w_area),
            .o_quo   (w_quo[g]),
            .o_sts   (w_sts[g])
        );
    end

    // ------------------------------------------------------------------
    // sequencer and merged output word
    // ------------------------------------------------------------------
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_out_load = (r_state == S_OUT) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_state <= w_ctl.div_start ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    if (w_sts[0].done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            r_avg[c] <= w_quo[c][CHANNEL_BITS-1:0] & AVG_MASK;
                        end
                        r_out_row    <= r_row;
                        r_out_col    <= r_idx;
                        r_frame_last <= r_last;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_avg_red    = r_avg[0];
    assign o_avg_green  = r_avg[1];
    assign o_avg_blue   = r_avg[2];
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_frame_last = r_frame_last;

`ifndef ASSERT_OFF
    a_upd_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> $past(w_in_acc))
        else $error("column update without an accepted word");

    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sts[0].done == w_sts[1].done) && (w_sts[0].done == w_sts[2].done))
        else $error("channel lanes finished out of step");

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_sts[0].busy)
        else $error("divider busy while taking new words");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("output word loaded outside the output step");
`endif

endmodule

[rtl/core/boxavg_ram.sv]
// ----------------------------------------------------------------------------
// boxavg_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module boxavg_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/boxavg_div.sv]
// ----------------------------------------------------------------------------
// boxavg_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module boxavg_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_busy,
    output logic             o_done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_trial;
    logic             w_bit;
    logic [DEN_W-1:0] n_rem;
    logic [NUM_W-1:0] n_quo;

    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_bit   = (w_trial >= {1'b0, r_den});
        n_rem   = w_bit ? DEN_W'(w_trial - {1'b0, r_den}) : DEN_W'(w_trial);
        n_quo   = {r_quo[NUM_W-2:0], w_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out on the left while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo  = r_quo;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

[rtl/core/boxavg_lane.sv]
// ----------------------------------------------------------------------------
// boxavg_lane
// One color channel: per-column sum memory, accumulate and block average.
// ----------------------------------------------------------------------------
module boxavg_lane import boxavg_pkg::*; #(
    parameter int CHANNEL_BITS = 8,
    parameter int SUM_W        = 16,
    parameter int DEPTH        = 1024,
    parameter int ADDR_W       = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_lane_ctl               i_ctl,
    input  logic [ADDR_W-1:0]       i_addr,
    input  logic [CHANNEL_BITS-1:0] i_px,
    input  logic [AREA_W-1:0]       i_area,
    output logic [SUM_W-1:0]        o_quo,
    output t_lane_sts               o_sts
);

    logic [SUM_W-1:0] w_rdata;
    logic [SUM_W-1:0] w_sum;

    // first row of a block row overwrites whatever the column held
    assign w_sum = i_ctl.fresh ? SUM_W'(i_px) : w_rdata + SUM_W'(i_px);

    boxavg_ram #(
        .WIDTH  (SUM_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.upd_en),
        .i_waddr (i_addr),
        .i_wdata (w_sum),
        .i_re    (i_ctl.rd_en),
        .i_raddr (i_addr),
        .o_rdata (w_rdata)
    );

    boxavg_div #(
        .NUM_W (SUM_W),
        .DEN_W (AREA_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_num   (w_sum),
        .i_den   (i_area),
        .o_quo   (o_quo),
        .o_busy  (o_sts.busy),
        .o_done  (o_sts.done)
    );

endmodule

[test/tb_box_average_downsampler.sv]
// ----------------------------------------------------------------------------
// tb_box_average_downsampler
// Self-checking bench for the box average downsampler. Streams raster RGB
// pixels under several block sizes and frame shapes, predicts every block
// average in step with the pixels taken, and compares each output word field
// by field while both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb_box_average_downsampler import boxavg_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_FACTOR    = 16;
    localparam int SETTLE_CYCLES = 48;
    localparam int MAX_REPORTS   = 200;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_start;
    } t_rgb_pixel;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
    } t_block_avg;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_SOURCE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_red_in      = '0;
    logic [7:0]            i_green_in    = '0;
    logic [7:0]            i_blue_in     = '0;
    logic                  i_frame_start = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic [7:0]            o_avg_red;
    logic [7:0]            o_avg_green;
    logic [7:0]            o_avg_blue;
    logic [ROW_W-1:0]      o_out_row;
    logic [9:0]            o_out_col;
    logic                  o_frame_last;

    box_average_downsampler #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_FACTOR   (MAX_FACTOR),
        .CHANNEL_BITS (8)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_avg_red     (o_avg_red),
        .o_avg_green   (o_avg_green),
        .o_avg_blue    (o_avg_blue),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_frame_last  (o_frame_last)
    );

    // predictor state
    int unsigned cfg_width  = 1;
    int unsigned cfg_height = 1;
    int unsigned cfg_factor = 1;
    int unsigned col_sum [CHANNELS][MAX_WIDTH];
    int unsigned pos_col, pos_row, in_blk_col, in_blk_row, blk_col, blk_row;

    t_block_avg  pending_avgs [$];
    int          mismatch_count = 0;
    int          hold_cycles    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          restart_due    = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("tb_box_average_downsampler: errors");
        $finish;
    end

    function automatic int unsigned limit_to(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_rgb_pixel make_pixel(input int r, input int g, input int b,
                                              input bit fs);
        t_rgb_pixel px;
        px.red         = 8'(r);
        px.green       = 8'(g);
        px.blue        = 8'(b);
        px.frame_start = fs;
        return px;
    endfunction

    function automatic logic [7:0] pick_level();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 8'd0;
        if (r < 20) return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    // one pixel taken: accumulate, maybe close a block, then step the raster
    function automatic void predict_downscale(input t_rgb_pixel px);
        int unsigned f, w, h, ow, oh, area;
        int unsigned chan [CHANNELS];
        t_block_avg  avg;
        f = limit_to(cfg_factor, MAX_FACTOR);
        w = limit_to(cfg_width, MAX_WIDTH);
        h = limit_to(cfg_height, MAX_HEIGHT);
        ow = w / f;
        oh = h / f;
        chan[0] = px.red;
        chan[1] = px.green;
        chan[2] = px.blue;
        if (px.frame_start) begin
            pos_col    = 0;
            pos_row    = 0;
            in_blk_col = 0;
            in_blk_row = 0;
            blk_col    = 0;
            blk_row    = 0;
        end
        if (blk_col < ow && blk_row < oh) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if (in_blk_row == 0) col_sum[c][blk_col] = chan[c];
                else col_sum[c][blk_col] += chan[c];
            end
            if (in_blk_col >= f - 1 && in_blk_row >= f - 1) begin
                area      = f * f;
                avg.red   = 8'(col_sum[0][blk_col] / area);
                avg.green = 8'(col_sum[1][blk_col] / area);
                avg.blue  = 8'(col_sum[2][blk_col] / area);
                avg.row   = 12'(blk_row);
                avg.col   = 10'(blk_col);
                avg.last  = (blk_col == ow - 1) && (blk_row == oh - 1);
                pending_avgs.push_back(avg);
            end
        end
        if (pos_col + 1 >= w) begin
            pos_col    = 0;
            in_blk_col = 0;
            blk_col    = 0;
            if (pos_row + 1 >= h) begin
                pos_row    = 0;
                in_blk_row = 0;
                blk_row    = 0;
            end else begin
                pos_row++;
                if (in_blk_row + 1 >= f) begin
                    in_blk_row = 0;
                    blk_row++;
                end else begin
                    in_blk_row++;
                end
            end
        end else begin
            pos_col++;
            if (in_blk_col + 1 >= f) begin
                in_blk_col = 0;
                blk_col++;
            end else begin
                in_blk_col++;
            end
        end
    endfunction

    function automatic void compare_field(input string name, input logic [11:0] want,
                                          input logic [11:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    // valid is left high after the handshake so back-to-back words need no toggle
    task automatic send_pixel(input t_rgb_pixel px);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        if (restart_due) begin
            px.frame_start = 1'b1;
            restart_due    = 1'b0;
        end
        i_in_valid    <= 1'b1;
        i_red_in      <= px.red;
        i_green_in    <= px.green;
        i_blue_in     <= px.blue;
        i_frame_start <= px.frame_start;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_downscale(px);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_avgs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // a new width or factor leaves the column sums stale, so the next pixel opens a frame
    task automatic set_config(input int unsigned w, input int unsigned h, input int unsigned f);
        int unsigned vals [3];
        drain_results();
        vals[0] = w;
        vals[1] = h;
        vals[2] = f;
        for (int i = 0; i < 3; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= (i == 0) ? CFG_SOURCE_WIDTH :
                           (i == 1) ? CFG_SOURCE_HEIGHT : CFG_FACTOR;
            i_cfg_data  <= CFG_DATA_W'(vals[i]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        if ((w & 32'h7FF) != cfg_width || (f & 32'h1F) != cfg_factor) restart_due = 1'b1;
        cfg_width  = w & 32'h7FF;
        cfg_height = h & 32'h1FFF;
        cfg_factor = f & 32'h1F;
    endtask

    task automatic test_directed();
        // reset settings: every pixel is its own block
        send_pixel(make_pixel(0, 0, 0, 1'b1));
        send_pixel(make_pixel(255, 255, 255, 1'b0));
        send_pixel(make_pixel(8'h55, 8'hAA, 8'h0F, 1'b0));
        // 2x2 blocks over a 4x2 frame, averages truncate
        set_config(4, 2, 2);
        send_pixel(make_pixel(255, 0, 10, 1'b1));
        send_pixel(make_pixel(255, 0, 20, 1'b0));
        send_pixel(make_pixel(0, 1, 30, 1'b0));
        send_pixel(make_pixel(1, 2, 40, 1'b0));
        send_pixel(make_pixel(255, 0, 30, 1'b0));
        send_pixel(make_pixel(255, 3, 40, 1'b0));
        send_pixel(make_pixel(2, 1, 50, 1'b0));
        send_pixel(make_pixel(2, 2, 60, 1'b0));
        // frame smaller than the block: nothing comes out
        set_config(3, 3, 31);
        send_pixel(make_pixel(255, 255, 255, 1'b1));
        send_pixel(make_pixel(0, 0, 0, 1'b0));
        send_pixel(make_pixel(128, 64, 32, 1'b0));
        drain_results();
    endtask

    // height shrinks mid-frame: the row counter is past the limit and wraps by itself
    task automatic test_height_change_midframe();
        set_config(4, 4, 2);
        for (int i = 0; i < 12; i++)
            send_pixel(make_pixel($urandom_range(255), $urandom_range(255),
                                  $urandom_range(255), i == 0));
        set_config(4, 2, 2);
        for (int i = 0; i < 12; i++)
            send_pixel(make_pixel($urandom_range(255), $urandom_range(255),
                                  $urandom_range(255), 1'b0));
        drain_results();
    endtask

    task automatic test_register_limits();
        // width above max and zero height and factor: one full-width row, then wrap
        set_config(2047, 0, 0);
        for (int i = 0; i < MAX_WIDTH + 2; i++)
            send_pixel(make_pixel(pick_level(), pick_level(), pick_level(), 1'b0));
        // height above max acts as the maximum: rows keep counting with no wrap
        set_config(1, 8191, 1);
        for (int i = 0; i < 48; i++)
            send_pixel(make_pixel(pick_level(), pick_level(), pick_level(), 1'b0));
        // factor above max acts as the largest block
        set_config(16, 16, 31);
        for (int i = 0; i < 256; i++)
            send_pixel(make_pixel(pick_level(), pick_level(), pick_level(), 1'b0));
        drain_results();
    endtask

    // receiver holds off long enough for the block to back up into its input
    task automatic test_output_backpressure();
        set_config(8, 4, 1);
        hold_cycles = 400;
        for (int i = 0; i < 64; i++)
            send_pixel(make_pixel(pick_level(), pick_level(), pick_level(), i == 0));
        drain_results();
    endtask

    task automatic test_random_frames(input int target);
        int sent, r, raw_f, ef, fw, fh, frame_len, total, frames;
        bit fs;
        sent = 0;
        while (sent < target) begin
            r = $urandom_range(99);
            if (r < 5) raw_f = 0;
            else if (r < 20) raw_f = 1;
            else if (r < 45) raw_f = 2;
            else if (r < 75) raw_f = $urandom_range(3, 4);
            else if (r < 95) raw_f = $urandom_range(5, 16);
            else raw_f = $urandom_range(17, 31);
            ef = limit_to(raw_f, MAX_FACTOR);
            if (ef <= 4) begin
                fw = ef * $urandom_range(1, 6) + $urandom_range(0, ef - 1);
                fh = ef * $urandom_range(1, 4) + $urandom_range(0, ef - 1);
            end else if (ef <= 8) begin
                fw = ef * $urandom_range(1, 3) + $urandom_range(0, ef - 1);
                fh = ef + $urandom_range(0, ef - 1);
            end else begin
                fw = ef * $urandom_range(1, 2);
                fh = ef;
            end
            if (ef > 1 && $urandom_range(99) < 4) fw = $urandom_range(1, ef - 1);
            set_config(fw, fh, raw_f);
            frame_len = fw * fh;
            frames    = (frame_len > 200) ? 1 : $urandom_range(1, 3);
            total     = frames * frame_len;
            // now and then a frame is cut short
            if ($urandom_range(99) < 10) total = $urandom_range(1, total);
            for (int n = 0; n < total; n++) begin
                if (n % frame_len == 0) fs = ($urandom_range(99) < 70);
                else fs = ($urandom_range(199) == 0);
                send_pixel(make_pixel(pick_level(), pick_level(), pick_level(), fs));
            end
            sent += total;
        end
        drain_results();
    endtask

    initial begin : drive_out_stall
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    initial begin : check_avg
        t_block_avg want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (pending_avgs.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t ns: word expected none got rgb %0d %0d %0d row %0d col %0d",
                                 $time, o_avg_red, o_avg_green, o_avg_blue, o_out_row,
                                 o_out_col);
                end else begin
                    want = pending_avgs.pop_front();
                    compare_field("avg_red", want.red, o_avg_red);
                    compare_field("avg_green", want.green, o_avg_green);
                    compare_field("avg_blue", want.blue, o_avg_blue);
                    compare_field("out_row", want.row, o_out_row);
                    compare_field("out_col", want.col, o_out_col);
                    compare_field("frame_last", want.last, o_frame_last);
                end
            end
        end
    end

    initial begin
        foreach (col_sum[c, i]) col_sum[c][i] = 0;
        pos_col    = 0;
        pos_row    = 0;
        in_blk_col = 0;
        in_blk_row = 0;
        blk_col    = 0;
        blk_row    = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_height_change_midframe();
        test_register_limits();
        test_output_backpressure();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_frames(90);
        send_idle_pct  = 53;
        recv_stall_pct = 0;
        test_random_frames(90);
        send_idle_pct  = 0;
        recv_stall_pct = 53;
        test_random_frames(90);
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        test_random_frames(90);

        drain_results();
        if (mismatch_count == 0) begin
            $display("tb_box_average_downsampler: clean");
        end else begin
            $display("tb_box_average_downsampler: errors");
        end
        $finish;
    end

endmodule
